FILE: src/stc_pkg.sv
// Shared constants, reciprocal table and types for the Taylor-series sine block.
`timescale 1ns / 1ps
package stc_pkg;

  localparam int ANGLE_W       = 32;
  localparam int VALUE_W       = 40;
  localparam int TC_W          = 5;
  localparam logic [TC_W-1:0] TC_RESET = 5'd10;
  localparam int MAX_TERMS_DEF = 16;

  localparam int FRAC_BITS  = 28;
  localparam int RECIP_BITS = 48;

  // magnitudes of x, x^2, terms and reciprocals all stay below 2^48
  localparam int OP_W  = 48;
  localparam int DIG_W = 24;
  localparam int ACC_W = 2 * OP_W;
  localparam int SUM_W = 48;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh007F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 48'shFF80_0000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 40'h80_0000_0000;

  localparam int TAB_DEPTH = 32;
  localparam int TAB_IDX_W = 5;
  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_BITS;

  // round(2^48 / ((2n+2)(2n+3))), halves up
  localparam logic [63:0] RECIP_TAB [TAB_DEPTH] = '{
    (RECIP_ONE + 64'd3)    / 64'd6,
    (RECIP_ONE + 64'd10)   / 64'd20,
    (RECIP_ONE + 64'd21)   / 64'd42,
    (RECIP_ONE + 64'd36)   / 64'd72,
    (RECIP_ONE + 64'd55)   / 64'd110,
    (RECIP_ONE + 64'd78)   / 64'd156,
    (RECIP_ONE + 64'd105)  / 64'd210,
    (RECIP_ONE + 64'd136)  / 64'd272,
    (RECIP_ONE + 64'd171)  / 64'd342,
    (RECIP_ONE + 64'd210)  / 64'd420,
    (RECIP_ONE + 64'd253)  / 64'd506,
    (RECIP_ONE + 64'd300)  / 64'd600,
    (RECIP_ONE + 64'd351)  / 64'd702,
    (RECIP_ONE + 64'd406)  / 64'd812,
    (RECIP_ONE + 64'd465)  / 64'd930,
    (RECIP_ONE + 64'd528)  / 64'd1056,
    (RECIP_ONE + 64'd595)  / 64'd1190,
    (RECIP_ONE + 64'd666)  / 64'd1332,
    (RECIP_ONE + 64'd741)  / 64'd1482,
    (RECIP_ONE + 64'd820)  / 64'd1640,
    (RECIP_ONE + 64'd903)  / 64'd1806,
    (RECIP_ONE + 64'd990)  / 64'd1980,
    (RECIP_ONE + 64'd1081) / 64'd2162,
    (RECIP_ONE + 64'd1176) / 64'd2352,
    (RECIP_ONE + 64'd1275) / 64'd2550,
    (RECIP_ONE + 64'd1378) / 64'd2756,
    (RECIP_ONE + 64'd1485) / 64'd2970,
    (RECIP_ONE + 64'd1596) / 64'd3192,
    (RECIP_ONE + 64'd1711) / 64'd3422,
    (RECIP_ONE + 64'd1830) / 64'd3660,
    (RECIP_ONE + 64'd1953) / 64'd3906,
    (RECIP_ONE + 64'd2080) / 64'd4160
  };

  typedef struct packed {
    logic en;
    logic hi;
  } mac_ctrl_t;

endpackage

FILE: src/stc_in_if.sv
// Angle input channel: valid/ready handshake with the angle payload.
`timescale 1ns / 1ps
interface stc_in_if
  import stc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

FILE: src/stc_out_if.sv
// Result output channel: valid/ready handshake with sine value and clip flag.
`timescale 1ns / 1ps
interface stc_out_if
  import stc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sine_value;
  logic                      saturated;

  modport source (output valid, output sine_value, output saturated, input ready);
  modport sink   (input valid, input sine_value, input saturated, output ready);
endinterface

FILE: src/sine_taylor_series.sv
// Top level of the fixed-point Taylor-series sine block.
// Computes sin(angle) for a signed Q3.28 angle as the sum of the first
// term_count Taylor terms, returning a saturated Q11.28 value and a clip flag.
// All products go through one shared 24x48 multiplier: each 48x48 product
// takes two passes and is then rounded, so every term after the first
// costs a multiply by x^2, a multiply by the reciprocal and an accumulate.
// With N the term count clipped to MAX_TERMS (10 after reset), no new angle
// is taken until all N terms are summed and the result is loaded. The result
// sits in an output register, so a new angle is taken while the previous
// result waits. term_count is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module sine_taylor_series
  import stc_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [TC_W-1:0] cfg_wdata_i,
  stc_in_if.sink          angle_i,
  stc_out_if.source       result_o
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int CMP_W = TC_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_DISP   = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [1:0] OP_SQ = 2'd0;
  localparam logic [1:0] OP_MX = 2'd1;
  localparam logic [1:0] OP_RC = 2'd2;

  localparam logic [ACC_W-1:0] HALF_FRAC  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] HALF_RECIP = ACC_W'(1) << (RECIP_BITS - 1);

  logic [2:0]              state_d, state_q;
  logic [1:0]              op_d, op_q;
  logic [CNT_W-1:0]        n_d, n_q;
  logic [CNT_W-1:0]        count_d, count_q;
  logic                    neg_d, neg_q;
  logic [OP_W-1:0]         a_d, a_q;
  logic [OP_W-1:0]         b_d, b_q;
  logic [OP_W-1:0]         x2_d, x2_q;
  logic [OP_W-1:0]         term_d, term_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic [TC_W-1:0]         term_count_q;

  logic                      out_valid_d, out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_sat_q;
  logic                      out_load;

  mac_ctrl_t               mac_ctrl;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        half;
  logic [OP_W-1:0]         rnd;
  logic [ANGLE_W-1:0]      x_mag;
  logic [CNT_W-1:0]        count_lim;
  logic [OP_W-1:0]         recip;
  logic signed [SUM_W-1:0] term_s;
  logic                    clip_hi, clip_lo;

  assign x_mag = angle_i.angle[ANGLE_W-1] ? ANGLE_W'(-angle_i.angle)
                                          : ANGLE_W'(angle_i.angle);
  assign count_lim = ({1'b0, term_count_q} > CMP_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                                 : CNT_W'(term_count_q);
  assign recip  = OP_W'(RECIP_TAB[TAB_IDX_W'(n_q)]);
  assign half   = (op_q == OP_RC) ? HALF_RECIP : HALF_FRAC;
  assign rnd    = (op_q == OP_RC) ? acc[RECIP_BITS +: OP_W] : acc[FRAC_BITS +: OP_W];
  assign term_s = $signed(SUM_W'(term_q));

  stc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (a_q),
    .b_i    (b_q),
    .half_i (half),
    .acc_o  (acc)
  );

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    n_d      = n_q;
    count_d  = count_q;
    neg_d    = neg_q;
    a_d      = a_q;
    b_d      = b_q;
    x2_d     = x2_q;
    term_d   = term_q;
    sum_d    = sum_q;
    mac_ctrl = '0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (angle_i.valid) begin
          neg_d   = angle_i.angle[ANGLE_W-1];
          a_d     = OP_W'(x_mag);
          b_d     = OP_W'(x_mag);
          term_d  = OP_W'(x_mag);
          n_d     = '0;
          sum_d   = '0;
          count_d = count_lim;
          op_d    = OP_SQ;
          state_d = (count_lim == '0) ? S_FIN : S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        mac_ctrl.en = 1'b1;
        state_d     = S_MUL_HI;
      end
      S_MUL_HI: begin
        mac_ctrl.en = 1'b1;
        mac_ctrl.hi = 1'b1;
        state_d     = S_DISP;
      end
      S_DISP: begin
        case (op_q)
          OP_SQ: begin
            x2_d    = rnd;
            state_d = S_ADD;
          end
          OP_MX: begin
            a_d     = rnd;
            b_d     = recip;
            op_d    = OP_RC;
            state_d = S_MUL_LO;
          end
          OP_RC: begin
            term_d  = rnd;
            n_d     = CNT_W'(n_q + 1'b1);
            state_d = S_ADD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD: begin
        sum_d = (neg_q ^ n_q[0]) ? sum_q - term_s : sum_q + term_s;
        if (CNT_W'(n_q + 1'b1) == count_q) begin
          state_d = S_FIN;
        end else begin
          a_d     = term_q;
          b_d     = x2_q;
          op_d    = OP_MX;
          state_d = S_MUL_LO;
        end
      end
      S_FIN: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign clip_hi = sum_q > SUM_MAX;
  assign clip_lo = sum_q < SUM_MIN;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      term_count_q <= TC_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        term_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    n_q     <= n_d;
    count_q <= count_d;
    neg_q   <= neg_d;
    a_q     <= a_d;
    b_q     <= b_d;
    x2_q    <= x2_d;
    term_q  <= term_d;
    sum_q   <= sum_d;
    if (out_load) begin
      out_sat_q <= clip_hi | clip_lo;
      if (clip_hi) begin
        out_value_q <= VALUE_MAX;
      end else if (clip_lo) begin
        out_value_q <= VALUE_MIN;
      end else begin
        out_value_q <= sum_q[VALUE_W-1:0];
      end
    end
  end

  assign angle_i.ready       = (state_q == S_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.sine_value = out_value_q;
  assign result_o.saturated  = out_sat_q;

endmodule

FILE: src/stc_mac.sv
// Shared 24x48 multiply-accumulate unit; a 48x48 product takes two passes.
`timescale 1ns / 1ps
module stc_mac
  import stc_pkg::*;
(
  input  logic             clk_i,
  input  mac_ctrl_t        ctrl_i,
  input  logic [OP_W-1:0]  a_i,
  input  logic [OP_W-1:0]  b_i,
  input  logic [ACC_W-1:0] half_i,
  output logic [ACC_W-1:0] acc_o
);

  localparam int PROD_W = DIG_W + OP_W;

  logic [DIG_W-1:0]  digit;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_d, acc_q;

  assign digit = ctrl_i.hi ? a_i[OP_W-1:DIG_W] : a_i[DIG_W-1:0];
  assign prod  = digit * b_i;

  always_comb begin
    if (ctrl_i.hi) begin
      acc_d = acc_q + (ACC_W'(prod) << DIG_W);
    end else begin
      acc_d = ACC_W'(prod) + half_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: src/stc_checker.sv
// Port-level assertions for the Taylor-series sine block, bound to the top level.
`timescale 1ns / 1ps
module stc_checker
  import stc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [VALUE_W-1:0] out_value_i,
  input logic               out_sat_i
);

  // one angle at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_sat_i))
    else $error("stalled result beat changed");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sat_i |-> (out_value_i == VALUE_MAX || out_value_i == VALUE_MIN))
    else $error("saturated result not at a range bound");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while block was idle");

endmodule

bind sine_taylor_series stc_checker u_stc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (angle_i.valid),
  .in_ready_i  (angle_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_value_i (result_o.sine_value),
  .out_sat_i   (result_o.saturated)
);
